FILE: rtl/apow_pkg.sv
// Shared constants, operation codes and controller/datapath interface types
// for the approximate float power block. No dependencies.
`default_nettype none

package apow_pkg;

	localparam int INT_EXP_BITS_DEF = 8;

	// Bias of the bit-pattern trick, as an integer and as its rounded float.
	localparam logic [31:0] POW_BIAS       = 32'd1064774667;
	localparam logic [31:0] POW_BIAS_F     = 32'h4E7DDCB0;
	localparam logic [31:0] FP_ONE         = 32'h3F800000;
	localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC00000;

	// Float unit operations.
	localparam logic [1:0] FOP_MUL = 2'd0;
	localparam logic [1:0] FOP_ADD = 2'd1;
	localparam logic [1:0] FOP_I2F = 2'd2;

	// Datapath operand and destination selections.
	localparam logic [3:0] SEL_I2F_D    = 4'd0;
	localparam logic [3:0] SEL_MUL_E    = 4'd1;
	localparam logic [3:0] SEL_I2F_N    = 4'd2;
	localparam logic [3:0] SEL_SUB_N    = 4'd3;
	localparam logic [3:0] SEL_MUL_FRAC = 4'd4;
	localparam logic [3:0] SEL_ADD_K    = 4'd5;
	localparam logic [3:0] SEL_MUL_R    = 4'd6;
	localparam logic [3:0] SEL_MUL_SQ   = 4'd7;
	localparam logic [3:0] SEL_MUL_FIN  = 4'd8;

	typedef struct packed {
		logic       load;
		logic       issue;
		logic       wr;
		logic       step;
		logic [3:0] sel;
	} cmd_t;

	typedef struct packed {
		logic fpu_done;
		logic precise;
		logic cur_nz;
		logic rest_nz;
		logic bit_now;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/approximate_float_power_top.sv
// Top level of the approximate float power block: sequencer plus datapath.
// Depends on apow_pkg, apow_ctrl, apow_dp (and apow_fpu below it).
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+---------------------------------------------
//   command  | start / busy     | opcode, base_bits, exponent_bits
//   result   | done (one cycle) | power_bits, exponent_out_of_range
//
// A command transfer happens on a rising edge with start high and busy low.
// Every float operation runs on the one shared three-stage float unit. Fast
// mode (and an out-of-range exponent) needs three operations. Precise mode
// needs five operations, one multiply per set bit of the integer part, one
// square per bit below its highest set bit, and a final multiply; a loop
// decision state precedes the loop and follows each square. The result is
// held for the one cycle that done is high; busy is low in that cycle, so
// the next command can transfer. Reset returns the sequencer to idle; no
// result can be held off.
`default_nettype none

module approximate_float_power_top #(
	parameter int INT_EXP_BITS = apow_pkg::INT_EXP_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [31:0] base_bits,
	input  wire logic [31:0] exponent_bits,
	output logic             done,
	output logic [31:0]      power_bits,
	output logic             exponent_out_of_range
);

	apow_pkg::cmd_t    cmd;
	apow_pkg::status_t status;

	apow_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	apow_dp #(
		.INT_EXP_BITS (INT_EXP_BITS)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.status                (status),
		.opcode                (opcode),
		.base_bits             (base_bits),
		.exponent_bits         (exponent_bits),
		.power_bits            (power_bits),
		.exponent_out_of_range (exponent_out_of_range)
	);

endmodule

`default_nettype wire

FILE: rtl/apow_fpu.sv
// Shared single-precision unit: multiply, add and signed integer conversion,
// three stages (operate, normalize, round). Depends on apow_pkg.
`default_nettype none

module apow_fpu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        issue,
	input  wire logic [1:0]  fop,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] i_mag,
	input  wire logic        i_neg,
	output logic             done,
	output logic [31:0]      res
);

	// Operate stage.
	logic              f_sign;
	logic signed [10:0] f_ex;
	logic [49:0]       f_mag;
	logic              f_spec;
	logic [31:0]       f_specv;

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic [7:0]  xa, xb;
	logic [47:0] prod;
	logic        swap, eff_sub, stk;
	logic [31:0] big, sml;
	logic [23:0] mbig, msml;
	logic [7:0]  xbig, xsml, ediff;
	logic [49:0] big_w, sml_w, sml_sh, sml_j, sum;

	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
		a_zero = (a[30:0] == '0);
		b_zero = (b[30:0] == '0);
		ma = {a[30:23] != '0, a[22:0]};
		mb = {b[30:23] != '0, b[22:0]};
		xa = (a[30:23] == '0) ? 8'd1 : a[30:23];
		xb = (b[30:23] == '0) ? 8'd1 : b[30:23];
		prod = ma * mb;

		swap = b[30:0] > a[30:0];
		big  = swap ? b : a;
		sml  = swap ? a : b;
		mbig = {big[30:23] != '0, big[22:0]};
		msml = {sml[30:23] != '0, sml[22:0]};
		xbig = (big[30:23] == '0) ? 8'd1 : big[30:23];
		xsml = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
		ediff = xbig - xsml;
		big_w = {1'b0, mbig, 25'd0};
		sml_w = {1'b0, msml, 25'd0};
		if (ediff >= 8'd50) begin
			sml_sh = '0;
			stk    = msml != '0;
		end else begin
			sml_sh = sml_w >> ediff;
			stk    = (sml_sh << ediff) != sml_w;
		end
		// The sticky bit is jammed into the lowest position before the add.
		sml_j   = sml_sh | {49'd0, stk};
		eff_sub = big[31] ^ sml[31];
		sum     = eff_sub ? (big_w - sml_j) : (big_w + sml_j);

		f_sign  = 1'b0;
		f_ex    = '0;
		f_mag   = '0;
		f_spec  = 1'b0;
		f_specv = '0;
		case (fop)
			apow_pkg::FOP_MUL: begin
				f_sign = a[31] ^ b[31];
				f_ex   = $signed({3'd0, xa}) + $signed({3'd0, xb}) - 11'sd127;
				f_mag  = {prod, 2'b00};
				f_spec = a_nan || b_nan || a_inf || b_inf;
				if (a_nan)
					f_specv = a | 32'h0040_0000;
				else if (b_nan)
					f_specv = b | 32'h0040_0000;
				else if ((a_inf && b_zero) || (a_zero && b_inf))
					f_specv = apow_pkg::FP_DEFAULT_NAN;
				else
					f_specv = {a[31] ^ b[31], 31'h7F80_0000};
			end
			apow_pkg::FOP_ADD: begin
				// An exact cancellation rounds to plus zero.
				f_sign = (eff_sub && (sum == '0)) ? 1'b0 : big[31];
				f_ex   = $signed({3'd0, xbig});
				f_mag  = sum;
				f_spec = a_nan || b_nan || a_inf || b_inf;
				if (a_nan)
					f_specv = a | 32'h0040_0000;
				else if (b_nan)
					f_specv = b | 32'h0040_0000;
				else if (a_inf && b_inf && (a[31] != b[31]))
					f_specv = apow_pkg::FP_DEFAULT_NAN;
				else if (a_inf)
					f_specv = a;
				else
					f_specv = b;
			end
			apow_pkg::FOP_I2F: begin
				f_sign = i_neg;
				f_ex   = 11'sd157;
				f_mag  = {i_mag, 18'd0};
			end
			default: begin
				f_spec  = 1'b1;
				f_specv = apow_pkg::FP_DEFAULT_NAN;
			end
		endcase
	end

	logic               v_s1, sign_s1, spec_s1;
	logic signed [10:0] ex_s1;
	logic [49:0]        mag_s1;
	logic [31:0]        specv_s1;

	// Normalize stage.
	logic [5:0]         lz;
	logic [49:0]        norm;
	logic signed [10:0] e2;

	always_comb begin
		lz = '0;
		for (int i = 0; i < 50; i++) begin
			if (mag_s1[i])
				lz = 6'(49 - i);
		end
		norm = mag_s1 << lz;
		e2   = ex_s1 + 11'sd1 - $signed({5'd0, lz});
	end

	logic               v_s2, sign_s2, spec_s2, zero_s2;
	logic signed [10:0] e2_s2;
	logic [49:0]        norm_s2;
	logic [31:0]        specv_s2;

	// Round stage.
	logic signed [10:0] dn;
	logic [5:0]         sh;
	logic [49:0]        shifted;
	logic [23:0]        m24;
	logic               g, st, inc;
	logic [7:0]         field;
	logic [30:0]        packed_v;
	logic [31:0]        rnd;

	always_comb begin
		dn = 11'sd1 - e2_s2;
		if (e2_s2 >= 11'sd1)
			sh = '0;
		else if (dn > 11'sd63)
			sh = 6'd63;
		else
			sh = dn[5:0];
		shifted  = norm_s2 >> sh;
		m24      = shifted[49:26];
		g        = shifted[25];
		st       = ((shifted << sh) != norm_s2) || (shifted[24:0] != '0);
		inc      = g & (st | m24[0]);
		field    = (e2_s2 >= 11'sd1) ? e2_s2[7:0] : 8'd0;
		packed_v = {field, m24[22:0]} + {30'd0, inc};
		if (spec_s2)
			rnd = specv_s2;
		else if (zero_s2)
			rnd = {sign_s2, 31'd0};
		else if (e2_s2 >= 11'sd255)
			rnd = {sign_s2, 31'h7F80_0000};
		else
			rnd = {sign_s2, packed_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sign_s1  <= f_sign;
		ex_s1    <= f_ex;
		mag_s1   <= f_mag;
		spec_s1  <= f_spec;
		specv_s1 <= f_specv;
		sign_s2  <= sign_s1;
		e2_s2    <= e2;
		norm_s2  <= norm;
		spec_s2  <= spec_s1;
		specv_s2 <= specv_s1;
		zero_s2  <= mag_s1 == '0;
		res      <= rnd;
	end

endmodule

`default_nettype wire

FILE: rtl/apow_dp.sv
// Datapath: operand registers, integer part and range check, result
// registers and the shared float unit. Depends on apow_pkg and apow_fpu.
`default_nettype none

module apow_dp #(
	parameter int INT_EXP_BITS = apow_pkg::INT_EXP_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire apow_pkg::cmd_t    cmd,
	output apow_pkg::status_t      status,
	input  wire logic              opcode,
	input  wire logic [31:0]       base_bits,
	input  wire logic [31:0]       exponent_bits,
	output logic [31:0]            power_bits,
	output logic                   exponent_out_of_range
);

	localparam int IW = (INT_EXP_BITS > 1) ? $clog2(INT_EXP_BITS) : 1;
	localparam logic [30:0] LIM_BITS = 31'((127 + INT_EXP_BITS) * (2 ** 23));

	logic          op_q;
	logic [31:0]   base_q, exp_q, fd_q, t_q, r_q, sq_q, approx_q, power_q;
	logic [IW-1:0] i_q;

	function automatic logic [31:0] sat_u32(input logic [31:0] y);
		logic [55:0] w;
		logic [31:0] v;
		logic [7:0]  sh;
		sh = y[30:23] - 8'd127;
		w  = {32'd0, 1'b1, y[22:0]} << sh[4:0];
		if (y[31] || (y[30:23] < 8'd127) || ((y[30:23] == 8'hFF) && (y[22:0] != '0)))
			v = '0;
		else if (y[30:23] >= 8'd159)
			v = 32'hFFFF_FFFF;
		else
			v = w[54:23];
		return v;
	endfunction

	// Range check and integer part of the exponent.
	logic                    oor;
	logic [7:0]              e_sh;
	logic [55:0]             n_full;
	logic [INT_EXP_BITS-1:0] n_w, n_at;
	logic [31:0]             diff, diff_abs;

	always_comb begin
		oor = ((exp_q[30:23] == 8'hFF) && (exp_q[22:0] != '0))
			|| (exp_q[31] && (exp_q[30:0] >= 31'h3F80_0000))
			|| (!exp_q[31] && (exp_q[30:0] >= LIM_BITS));
		e_sh   = exp_q[30:23] - 8'd127;
		n_full = {32'd0, 1'b1, exp_q[22:0]} << e_sh[4:0];
		if (exp_q[31] || (exp_q[30:23] < 8'd127))
			n_w = '0;
		else
			n_w = n_full[23 +: INT_EXP_BITS];
		n_at     = n_w >> i_q;
		diff     = base_q - apow_pkg::POW_BIAS;
		diff_abs = diff[31] ? (~diff + 32'd1) : diff;
	end

	assign status.precise = op_q & ~oor;
	assign status.cur_nz  = n_at != '0;
	assign status.rest_nz = (n_at >> 1) != '0;
	assign status.bit_now = n_at[0];

	// Operand selection for the float unit.
	logic [1:0]  fop;
	logic [31:0] fa, fb, i_mag, fpu_res;
	logic        i_neg, fpu_done;

	always_comb begin
		fop   = apow_pkg::FOP_MUL;
		fa    = '0;
		fb    = '0;
		i_mag = diff_abs;
		i_neg = diff[31];
		unique case (cmd.sel) inside
			apow_pkg::SEL_I2F_D: begin
				fop = apow_pkg::FOP_I2F;
			end
			apow_pkg::SEL_I2F_N: begin
				fop   = apow_pkg::FOP_I2F;
				i_mag = 32'(n_w);
				i_neg = 1'b0;
			end
			apow_pkg::SEL_MUL_E: begin
				fa = exp_q;
				fb = fd_q;
			end
			apow_pkg::SEL_SUB_N: begin
				fop = apow_pkg::FOP_ADD;
				fa  = exp_q;
				fb  = {~t_q[31], t_q[30:0]};
			end
			apow_pkg::SEL_MUL_FRAC: begin
				fa = t_q;
				fb = fd_q;
			end
			apow_pkg::SEL_ADD_K: begin
				fop = apow_pkg::FOP_ADD;
				fa  = t_q;
				fb  = apow_pkg::POW_BIAS_F;
			end
			apow_pkg::SEL_MUL_R: begin
				fa = r_q;
				fb = sq_q;
			end
			apow_pkg::SEL_MUL_SQ: begin
				fa = sq_q;
				fb = sq_q;
			end
			apow_pkg::SEL_MUL_FIN: begin
				fa = r_q;
				fb = approx_q;
			end
			default: begin
				fa = '0;
			end
		endcase
	end

	apow_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (cmd.issue),
		.fop    (fop),
		.a      (fa),
		.b      (fb),
		.i_mag  (i_mag),
		.i_neg  (i_neg),
		.done   (fpu_done),
		.res    (fpu_res)
	);

	assign status.fpu_done = fpu_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (cmd.load) begin
			i_q <= '0;
		end else if (cmd.step) begin
			i_q <= i_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			base_q <= base_bits;
			exp_q  <= exponent_bits;
			r_q    <= apow_pkg::FP_ONE;
			sq_q   <= base_bits;
		end else if (cmd.wr) begin
			unique case (cmd.sel) inside
				apow_pkg::SEL_I2F_D: fd_q <= fpu_res;
				apow_pkg::SEL_I2F_N, apow_pkg::SEL_SUB_N,
				apow_pkg::SEL_MUL_E, apow_pkg::SEL_MUL_FRAC: t_q <= fpu_res;
				apow_pkg::SEL_ADD_K: begin
					approx_q <= sat_u32(fpu_res);
					power_q  <= sat_u32(fpu_res);
				end
				apow_pkg::SEL_MUL_R: r_q <= fpu_res;
				apow_pkg::SEL_MUL_SQ: sq_q <= fpu_res;
				apow_pkg::SEL_MUL_FIN: power_q <= fpu_res;
				default: power_q <= power_q;
			endcase
		end
	end

	assign power_bits            = power_q;
	assign exponent_out_of_range = op_q & oor;

endmodule

`default_nettype wire

FILE: rtl/apow_ctrl.sv
// Sequencer that steps the datapath through the float operations of one item.
// Depends on apow_pkg.
`default_nettype none

module apow_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output apow_pkg::cmd_t         cmd,
	input  wire apow_pkg::status_t status
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FD   = 4'd1;
	localparam logic [3:0] S_ME   = 4'd2;
	localparam logic [3:0] S_NF   = 4'd3;
	localparam logic [3:0] S_SUB  = 4'd4;
	localparam logic [3:0] S_MF   = 4'd5;
	localparam logic [3:0] S_ADDK = 4'd6;
	localparam logic [3:0] S_LOOP = 4'd7;
	localparam logic [3:0] S_MR   = 4'd8;
	localparam logic [3:0] S_SQ   = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0] state_q, state_d;
	logic       issued_q, op_state, load;

	assign busy     = (state_q != S_IDLE) && (state_q != S_OUT);
	assign done     = state_q == S_OUT;
	assign load     = start && !busy;
	assign op_state = busy && (state_q != S_LOOP);

	always_comb begin
		cmd.load  = load;
		cmd.issue = op_state && !issued_q;
		cmd.wr    = op_state && status.fpu_done;
		cmd.step  = (state_q == S_SQ) && status.fpu_done;
		unique case (state_q)
			S_FD:    cmd.sel = apow_pkg::SEL_I2F_D;
			S_ME:    cmd.sel = apow_pkg::SEL_MUL_E;
			S_NF:    cmd.sel = apow_pkg::SEL_I2F_N;
			S_SUB:   cmd.sel = apow_pkg::SEL_SUB_N;
			S_MF:    cmd.sel = apow_pkg::SEL_MUL_FRAC;
			S_ADDK:  cmd.sel = apow_pkg::SEL_ADD_K;
			S_MR:    cmd.sel = apow_pkg::SEL_MUL_R;
			S_SQ:    cmd.sel = apow_pkg::SEL_MUL_SQ;
			S_FIN:   cmd.sel = apow_pkg::SEL_MUL_FIN;
			default: cmd.sel = apow_pkg::SEL_I2F_D;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			S_IDLE, S_OUT: state_d = load ? S_FD : S_IDLE;
			S_FD:   if (status.fpu_done) state_d = status.precise ? S_NF : S_ME;
			S_ME:   if (status.fpu_done) state_d = S_ADDK;
			S_NF:   if (status.fpu_done) state_d = S_SUB;
			S_SUB:  if (status.fpu_done) state_d = S_MF;
			S_MF:   if (status.fpu_done) state_d = S_ADDK;
			S_ADDK: if (status.fpu_done) state_d = status.precise ? S_LOOP : S_OUT;
			S_LOOP: begin
				// Squares stop once no higher bit of the integer part is left.
				if (!status.cur_nz)
					state_d = S_FIN;
				else if (status.bit_now)
					state_d = S_MR;
				else
					state_d = S_SQ;
			end
			S_MR:   if (status.fpu_done) state_d = status.rest_nz ? S_SQ : S_FIN;
			S_SQ:   if (status.fpu_done) state_d = S_LOOP;
			S_FIN:  if (status.fpu_done) state_d = S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wr)
				issued_q <= 1'b0;
			else if (cmd.issue)
				issued_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: bench/approximate_float_power_top_tb.sv
// Self-checking testbench for approximate_float_power_top: directed and random
// commands, with results predicted by a bit-exact single-precision float model.
// Depends on apow_pkg and the RTL of the block.
`timescale 1ns / 1ps

module approximate_float_power_top_tb;

	localparam int EXP_BITS = apow_pkg::INT_EXP_BITS_DEF;
	localparam logic OP_FAST    = 1'b0;
	localparam logic OP_PRECISE = 1'b1;

	typedef struct {
		logic [31:0] power;
		logic        oor;
	} power_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        opcode = 1'b0;
	logic [31:0] base_bits = '0;
	logic [31:0] exponent_bits = '0;
	logic        busy, done, exponent_out_of_range;
	logic [31:0] power_bits;

	power_result_t pending_powers[$];
	int mismatches = 0;
	int results_seen = 0;
	int commands_sent = 0;
	int idle_pct = 0;

	approximate_float_power_top #(.INT_EXP_BITS(EXP_BITS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .base_bits(base_bits), .exponent_bits(exponent_bits),
		.done(done), .power_bits(power_bits),
		.exponent_out_of_range(exponent_out_of_range)
	);

	always #5 clk = ~clk;

	// ---------------- single-precision arithmetic ----------------

	function automatic bit is_nan(logic [31:0] f);
		return f[30:23] == 8'hFF && f[22:0] != 0;
	endfunction

	function automatic bit is_inf(logic [31:0] f);
		return f[30:23] == 8'hFF && f[22:0] == 0;
	endfunction

	function automatic real float_to_real(logic [31:0] f);
		logic [63:0] d;
		if (f[30:23] == 8'hFF) begin
			d = {f[31], 11'h7FF, 52'd0};
			return $bitstoreal(d);
		end
		if (f[30:23] == 0) begin
			if (f[31])
				return -(real'(f[22:0]) * 2.0 ** (-149));
			return real'(f[22:0]) * 2.0 ** (-149);
		end
		d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
		return $bitstoreal(d);
	endfunction

	// Rounds a real to the nearest single, ties to even, subnormals included.
	function automatic logic [31:0] round_to_float(real x);
		logic [63:0] d;
		logic        s;
		longint unsigned sig, q, rem, half;
		int fe, shift;
		d = $realtobits(x);
		s = d[63];
		if (d[62:52] == 11'h7FF)
			return {s, 8'hFF, 23'd0};
		if (d[62:0] == 0)
			return {s, 31'd0};
		sig = {11'd0, 1'b1, d[51:0]};
		fe = int'(d[62:52]) - 1023 + 127;
		shift = (fe >= 1) ? 29 : 30 - fe;
		if (shift > 54)
			return {s, 31'd0};
		q = sig >> shift;
		rem = sig & ((64'd1 << shift) - 1);
		half = 64'd1 << (shift - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 1;
		if (fe >= 1) begin
			if (q == (64'd1 << 24)) begin
				q = q >> 1;
				fe = fe + 1;
			end
			if (fe >= 255)
				return {s, 8'hFF, 23'd0};
			return {s, fe[7:0], q[22:0]};
		end
		return {s, q[30:0]};
	endfunction

	// A NaN operand comes back quieted, the first operand taking precedence.
	function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
		if (is_nan(a))
			return a | 32'h0040_0000;
		if (is_nan(b))
			return b | 32'h0040_0000;
		if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
			return apow_pkg::FP_DEFAULT_NAN;
		return round_to_float(float_to_real(a) * float_to_real(b));
	endfunction

	function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
		if (is_nan(a))
			return a | 32'h0040_0000;
		if (is_nan(b))
			return b | 32'h0040_0000;
		if (is_inf(a) && is_inf(b) && a[31] != b[31])
			return apow_pkg::FP_DEFAULT_NAN;
		return round_to_float(float_to_real(a) + float_to_real(b));
	endfunction

	// Truncates a non-negative finite value below 2^32 to an integer.
	function automatic longint unsigned trunc_to_uint(logic [31:0] f);
		longint unsigned m;
		int sh;
		if (f[30:23] < 127)
			return 0;
		m = {40'd0, 1'b1, f[22:0]};
		sh = int'(f[30:23]) - 150;
		return (sh >= 0) ? (m << sh) : (m >> -sh);
	endfunction

	function automatic logic [31:0] saturate_bits(logic [31:0] y);
		if (is_nan(y) || y[31] || y[30:0] == 0)
			return 32'd0;
		if (y[30:23] >= 8'd159)
			return 32'hFFFFFFFF;
		return 32'(trunc_to_uint(y));
	endfunction

	function automatic logic [31:0] bit_trick_power(logic [31:0] base, logic [31:0] e);
		logic signed [31:0] diff;
		logic [31:0] fd;
		diff = base - apow_pkg::POW_BIAS;
		fd = round_to_float(real'(diff));
		return saturate_bits(fadd(fmul(e, fd), apow_pkg::POW_BIAS_F));
	endfunction

	function automatic power_result_t predict_power(logic op, logic [31:0] base,
			logic [31:0] e);
		power_result_t res;
		logic [31:0] frac, approx, r, sq, n_f;
		int unsigned n;
		res.oor = 1'b0;
		if (op == OP_FAST) begin
			res.power = bit_trick_power(base, e);
			return res;
		end
		if (is_nan(e) || float_to_real(e) <= -1.0 || float_to_real(e) >= 2.0 ** EXP_BITS) begin
			res.oor = 1'b1;
			res.power = bit_trick_power(base, e);
			return res;
		end
		n = (!e[31] && e[30:0] != 0) ? int'(trunc_to_uint(e)) : 0;
		n_f = round_to_float(real'(n));
		frac = fadd(e, {~n_f[31], n_f[30:0]});
		approx = bit_trick_power(base, frac);
		r = apow_pkg::FP_ONE;
		sq = base;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (n[i])
				r = fmul(r, sq);
			sq = fmul(sq, sq);
		end
		res.power = fmul(r, approx);
		return res;
	endfunction

	// ---------------- stimulus and checking ----------------

	task automatic send_command(logic op, logic [31:0] base, logic [31:0] e);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		base_bits <= base;
		exponent_bits <= e;
		do @(posedge clk); while (busy);
		pending_powers.push_back(predict_power(op, base, e));
		commands_sent++;
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		power_result_t exp_res;
		if (arst_n && done) begin
			results_seen++;
			if (pending_powers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: power %h oor %b", power_bits,
						exponent_out_of_range);
			end else begin
				exp_res = pending_powers.pop_front();
				if (power_bits !== exp_res.power || exponent_out_of_range !== exp_res.oor) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected power %h oor %b, got power %h oor %b",
							exp_res.power, exp_res.oor, power_bits, exponent_out_of_range);
				end
			end
		end
	end

	function automatic logic [31:0] random_base();
		case ($urandom_range(5))
			0: return $urandom();
			1: return {1'($urandom_range(1)), 8'($urandom_range(118, 136)), 23'($urandom())};
			2: return {1'b0, 8'($urandom_range(124, 129)), 23'($urandom())};
			3: return apow_pkg::POW_BIAS + 32'($signed($urandom_range(0, 2000)) - 1000);
			4: return {1'($urandom_range(1)), 8'($urandom_range(0, 1) ? 8'hFF : 8'h00),
				23'($urandom_range(1) ? $urandom() : 0)};
			default: return {1'b0, 8'($urandom_range(100, 150)), 23'($urandom())};
		endcase
	endfunction

	function automatic logic [31:0] random_exponent();
		case ($urandom_range(4))
			0: return $urandom();
			1: return round_to_float(real'($urandom_range(0, 5300)) / 20.0 - 2.0);
			2: return round_to_float(real'($urandom_range(0, 400)) / 100.0 - 1.0);
			3: return round_to_float(real'($urandom_range(0, 16)) + 0.5 *
				real'($urandom_range(1)));
			default: return {1'($urandom_range(1)), 8'($urandom_range(110, 135)),
				23'($urandom())};
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] bases[10];
		logic [31:0] exps[10];
		bases = '{32'h0, 32'hFFFFFFFF, 32'h7F800000, 32'h7FC00000, apow_pkg::FP_ONE,
			32'h80000000, 32'h00000001, apow_pkg::POW_BIAS, apow_pkg::POW_BIAS - 1,
			32'h7FFFFFFF};
		exps = '{32'h0, 32'hBF000000, 32'hBF800000, 32'h437F8000, 32'h43800000,
			32'h7FC00000, 32'h7F800000, 32'hFF800000, 32'h40200000, apow_pkg::FP_ONE};
		idle_pct = 0;
		for (int i = 0; i < 10; i++) begin
			send_command(OP_PRECISE, 32'h3F8CCCCD, exps[i]);
			send_command(OP_FAST, bases[i], exps[(i + 3) % 10]);
		end
		send_command(OP_PRECISE, 32'h40000000, 32'h437F0000);
		send_command(OP_PRECISE, 32'hC0000000, 32'h40400000);
		send_command(OP_PRECISE, 32'h7F7FFFFF, 32'h40000000);
		wait_results_drained();
	endtask

	task automatic test_random_phase(int pct, int count);
		logic op;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(99) < 65) ? OP_PRECISE : OP_FAST;
			send_command(op, random_base(), random_exponent());
		end
	endtask

	task automatic test_pause_until_drained();
		idle_pct = 0;
		for (int i = 0; i < 5; i++)
			send_command(OP_PRECISE, random_base(), random_exponent());
		wait_results_drained();
		repeat (10) @(posedge clk);
		send_command(OP_FAST, random_base(), random_exponent());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(0, 450);
		test_pause_until_drained();
		test_random_phase(62, 450);
		test_random_phase(23, 450);
		wait_results_drained();
		repeat (100) @(posedge clk);
		$display("Sent %0d commands (fast and precise, specials, both idle patterns);",
			commands_sent);
		$display("checked %0d results, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && pending_powers.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d results outstanding.", pending_powers.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: approximate_float_power_top.f
rtl/apow_pkg.sv
rtl/apow_fpu.sv
rtl/apow_dp.sv
rtl/apow_ctrl.sv
rtl/approximate_float_power_top.sv
bench/approximate_float_power_top_tb.sv
